@@ sv/dbl_pkg.sv @@
// shared types, constants and helpers for the de bruijn node edge labeler
// no dependencies; imported by every module of the block
package dbl_pkg;

	localparam logic [2:0] SENTINEL   = 3'd4;
	localparam int         MAX_LABELS = 24;
	localparam int         LBL_W      = 5;
	localparam logic [3:0] W_DOLLAR   = 4'd0;
	localparam logic [3:0] W_FIRST    = 4'd1;
	localparam logic [3:0] W_REPEAT   = 4'd5;

	typedef logic [2:0] char_t;
	typedef logic [5:0] key_t;

	// solid masks of the current group, handed from the loader to the scanner
	typedef struct packed {
		logic [3:0] solid_out;
		logic [3:0] solid_pred;
	} grp_masks_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_EVAL,
		ST_FLUSH
	} dbl_state_t;

	// codes above the sentinel saturate to it
	function automatic char_t clamp_char(input char_t c);
		clamp_char = (c > SENTINEL) ? SENTINEL : c;
	endfunction

endpackage

@@ sv/dbl_if.sv @@
// valid/ready channel interfaces for edge records and emitted labels
// depends on nothing
interface dbl_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] edge_char;
	logic [2:0] pred_char;
	logic       group_end;

	modport source (output valid, output edge_char, output pred_char, output group_end,
		input ready);
	modport sink (input valid, input edge_char, input pred_char, input group_end,
		output ready);
endinterface

interface dbl_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] w_symbol;
	logic       is_last;
	logic       dollar_flag;
	logic       group_done;

	modport source (output valid, output w_symbol, output is_last, output dollar_flag,
		output group_done, input ready);
	modport sink (input valid, input w_symbol, input is_last, input dollar_flag,
		input group_done, output ready);
endinterface

@@ sv/dbl_run_mem.sv @@
// run store: one write port, one read port with registered read data
// depends on dbl_pkg
module dbl_run_mem #(
	parameter int DEPTH = 25,
	parameter int AW    = 5
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  dbl_pkg::key_t  wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output dbl_pkg::key_t  rd_data
);
	import dbl_pkg::*;

	key_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/dbl_scan.sv @@
// group-end scanner: walks the run store, filters runs and emits labels
// depends on dbl_pkg and dbl_out_if
module dbl_scan #(
	parameter int IDX_W    = 5,
	parameter int CNT_W    = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [CNT_W-1:0]          run_count,
	input  dbl_pkg::grp_masks_t       masks,
	input  logic [3:0][IDX_W-1:0]     last_run,
	output logic                      busy,
	output logic                      done,
	output logic                      rd_en,
	output logic [IDX_W-1:0]          rd_addr,
	input  dbl_pkg::key_t             rd_data,
	dbl_out_if.source                 lbl
);
	import dbl_pkg::*;

	dbl_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] k_q;
	logic [LBL_W-1:0] labels_q;
	logic [3:0]       emit_mask_q;
	logic             pend_valid_q;
	logic [3:0]       pend_w_q;
	logic             pend_last_q;
	logic             pend_dollar_q;
	logic             out_valid_q;
	logic [3:0]       out_w_q;
	logic             out_last_q;
	logic             out_dollar_q;
	logic             out_done_q;

	char_t      ra, rb;
	logic       drop;
	logic       slot_free;
	logic       take;
	logic       push;
	logic       push_done;
	logic       stay;
	logic       last_label;
	logic [3:0] w_new;
	logic       last_new;

	// decode of the run just read
	always_comb begin
		ra = rd_data[5:3];
		rb = rd_data[2:0];
		drop = ((ra == SENTINEL) && (rb != SENTINEL) && masks.solid_pred[rb[1:0]]) ||
			((rb == SENTINEL) && (ra != SENTINEL) && masks.solid_out[ra[1:0]]);
		if (rb == SENTINEL) begin
			w_new = W_DOLLAR;
		end else if (emit_mask_q[rb[1:0]]) begin
			w_new = {2'b00, rb[1:0]} + W_REPEAT;
		end else begin
			w_new = {2'b00, rb[1:0]} + W_FIRST;
		end
		last_new = (ra != SENTINEL) && (last_run[ra[1:0]] == k_q[IDX_W-1:0]);
		slot_free = !out_valid_q || lbl.ready;
		last_label = (labels_q == LBL_W'(MAX_LABELS - 1));
	end

	// control outputs of the scanner
	always_comb begin
		rd_en = 1'b0;
		rd_addr = k_q[IDX_W-1:0];
		take = 1'b0;
		push = 1'b0;
		push_done = 1'b0;
		done = 1'b0;
		stay = 1'b0;
		busy = (state_q != ST_LOAD);
		case (state_q)
			ST_LOAD: begin
			end
			ST_READ: begin
				rd_en = (k_q < run_count);
			end
			ST_EVAL: begin
				if (!drop) begin
					if (pend_valid_q && !slot_free) begin
						stay = 1'b1;
					end else begin
						take = 1'b1;
						push = pend_valid_q;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					done = 1'b1;
				end else if (slot_free) begin
					done = 1'b1;
					push = 1'b1;
					push_done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (start) state_nxt = ST_READ;
			end
			ST_READ: begin
				state_nxt = (k_q < run_count) ? ST_EVAL : ST_FLUSH;
			end
			ST_EVAL: begin
				if (drop) begin
					state_nxt = ST_READ;
				end else if (!stay) begin
					state_nxt = last_label ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (done) state_nxt = ST_LOAD;
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// scan control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			k_q <= '0;
			labels_q <= '0;
			emit_mask_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EVAL && !stay) begin
				k_q <= k_q + 1'b1;
			end
			if (take) begin
				labels_q <= labels_q + 1'b1;
				pend_valid_q <= 1'b1;
				if (rb != SENTINEL) emit_mask_q[rb[1:0]] <= 1'b1;
			end
			if (done) begin
				k_q <= '0;
				labels_q <= '0;
				emit_mask_q <= '0;
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (lbl.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending label and output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			pend_w_q <= w_new;
			pend_last_q <= last_new;
			pend_dollar_q <= (ra == SENTINEL);
		end
		if (push) begin
			out_w_q <= pend_w_q;
			out_last_q <= pend_last_q;
			out_dollar_q <= pend_dollar_q;
			out_done_q <= push_done;
		end
	end

	assign lbl.valid = out_valid_q;
	assign lbl.w_symbol = out_w_q;
	assign lbl.is_last = out_last_q;
	assign lbl.dollar_flag = out_dollar_q;
	assign lbl.group_done = out_done_q;

endmodule

@@ sv/debruijn_node_edge_labeler.sv @@
// top level of the de bruijn node edge labeler: record loader, run store, scanner
// depends on dbl_pkg, dbl_if, dbl_run_mem and dbl_scan
//
// usage:
//   rec carries sorted edge records (edge_char, pred_char, group_end) of one
//   node group; lbl carries one label per surviving run, at most MAX_LABELS (w_symbol,
//   is_last, dollar_flag, group_done), all with valid/ready.
//   records load at one per cycle while rec.ready is high; equal consecutive (a,b)
//   pairs merge into one run kept in the run store memory.
//   the transaction that carries group_end starts a scan of the run store:
//   each stored run is read through the single read port (ST_READ), then
//   evaluated once its registered read data is back (ST_EVAL); ST_FLUSH
//   finishes the group. rec.ready is low from the start of the scan until
//   it is done.
//   the last label of a group carries group_done.
//   labels go through an output register, so a stalled receiver holds the
//   scan but not the loading of the next group.
//   reset clears counters, masks and handshake state; the run store needs
//   no clearing since only entries written in the current group are read.
module debruijn_node_edge_labeler #(
	parameter int MAX_RUNS = 25
) (
	input  logic     clk,
	input  logic     arst_n,
	dbl_in_if.sink   rec,
	dbl_out_if.source lbl
);
	import dbl_pkg::*;

	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int CNT_W = $clog2(MAX_RUNS + 1);

	logic [CNT_W-1:0]      run_count_q;
	key_t                  prev_key_q;
	grp_masks_t            masks_q;
	logic [3:0][IDX_W-1:0] last_run_q;

	char_t            a, b;
	key_t             key;
	logic             accept;
	logic             match;
	logic             open_run;
	logic             stored;
	logic             solid;
	logic [3:0]       solid_out_new;
	logic [IDX_W-1:0] idx;
	logic             busy;
	logic             done;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	key_t             rd_data;

	// record decode and run collapse
	always_comb begin
		a = clamp_char(rec.edge_char);
		b = clamp_char(rec.pred_char);
		key = {a, b};
		accept = rec.valid && rec.ready;
		match = (run_count_q != '0) && (key == prev_key_q);
		open_run = !match && (run_count_q < CNT_W'(MAX_RUNS));
		stored = match || open_run;
		idx = match ? IDX_W'(run_count_q - 1'b1) : IDX_W'(run_count_q);
		solid = (a != SENTINEL) && (b != SENTINEL);
		solid_out_new = masks_q.solid_out;
		if (solid) solid_out_new[a[1:0]] = 1'b1;
	end

	assign rec.ready = !busy;

	// group state: run count and solid masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			masks_q <= '0;
		end else if (done) begin
			run_count_q <= '0;
			masks_q <= '0;
		end else if (accept && stored) begin
			if (open_run) run_count_q <= run_count_q + 1'b1;
			if (solid) begin
				masks_q.solid_out[a[1:0]] <= 1'b1;
				masks_q.solid_pred[b[1:0]] <= 1'b1;
			end
		end
	end

	// last key and last qualifying run per edge char
	always_ff @(posedge clk) begin
		if (accept && open_run) prev_key_q <= key;
		if (accept && stored && (a != SENTINEL) &&
			((b != SENTINEL) || !solid_out_new[a[1:0]])) begin
			last_run_q[a[1:0]] <= idx;
		end
	end

	dbl_run_mem #(
		.DEPTH (MAX_RUNS),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (accept && open_run),
		.wr_addr (idx),
		.wr_data (key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dbl_scan #(
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && rec.group_end),
		.run_count (run_count_q),
		.masks     (masks_q),
		.last_run  (last_run_q),
		.busy      (busy),
		.done      (done),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.lbl       (lbl)
	);

endmodule
